### sv/cpr_pkg.sv
// Package for the cone and plane raster generator.
// Holds widths, register indexes, figure codes and the cell-chain item types.
// No dependencies.
package cpr_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SINE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COSINE = 3'd4;

  localparam logic [1:0] KIND_UP    = 2'd0;
  localparam logic [1:0] KIND_DOWN  = 2'd1;
  localparam logic [1:0] KIND_PLANE = 2'd2;

  localparam logic [12:0] MIN_CELLS = 13'd2;
  localparam logic [12:0] MAX_CELLS = 13'd4096;

  // Square root: 60-bit radicand (sum of squares < 2^59), 30 result bits.
  localparam int SQ_W     = 60;
  localparam int SQ_CELLS = SQ_W / 2;

  typedef struct packed {
    logic               valid;
    logic               plane;
    logic               neg;
    logic               no_data;
    logic signed [31:0] pval;
  } side_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sq_t;

endpackage

### sv/cone_and_plane_raster_generator_top.sv
// Cone and plane raster generator, top level.
// Accepts one item per cycle, sustained, while busy is low.
// The pipeline is mostly the 30-cell square-root chain, one result bit per cell.
// Sync active-high rst clears pipeline valids and loads register defaults;
// busy is high during reset and the first cycle after it. The receiver cannot stall.
// Depends on cpr_pkg and cpr_sqrt_cell.
module cone_and_plane_raster_generator_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [11:0]                     column,
  input  logic [11:0]                     row,
  input  logic                            cfg_we,
  input  logic [cpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cpr_pkg::CFG_DAT_W-1:0]   cfg_data,
  output logic                            done,
  output logic signed [31:0]              height,
  output logic                            no_data
);
  import cpr_pkg::*;

  // Configuration registers
  logic [1:0]         figure_kind;
  logic [12:0]        side_count;
  logic [15:0]        cell_pitch;
  logic signed [15:0] plane_sine;
  logic signed [15:0] plane_cosine;

  always_ff @(posedge clk) begin
    if (rst) begin
      figure_kind  <= KIND_UP;
      side_count   <= 13'd100;
      cell_pitch   <= 16'd256;
      plane_sine   <= 16'sd6270;
      plane_cosine <= 16'sd15137;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KIND:   figure_kind  <= cfg_data[1:0];
        REG_COUNT:  side_count   <= cfg_data[12:0];
        REG_SIZE:   cell_pitch   <= cfg_data;
        REG_SINE:   plane_sine   <= $signed(cfg_data);
        REG_COSINE: plane_cosine <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // busy is rst registered, so it covers reset and the cycle right after it; otherwise an item per clock
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  // Clamp grid side to the supported range
  logic [12:0] n_clamped;
  always_comb begin
    if (side_count < MIN_CELLS) begin
      n_clamped = MIN_CELLS;
    end else if (side_count > MAX_CELLS) begin
      n_clamped = MAX_CELLS;
    end else begin
      n_clamped = side_count;
    end
  end

  // Stage 0: index * cell size, and full extent (= half extent in Q.9)
  logic        v0;
  logic [27:0] p_col, p_row, full0;
  logic [28:0] full_prod;
  assign full_prod = cell_pitch * n_clamped;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    p_col <= column * cell_pitch;
    p_row <= row * cell_pitch;
    full0 <= full_prod[27:0];   // max 65535*4096 < 2^28
  end

  // Stage 1: centered offsets in Q.9 world units
  logic               v1;
  logic signed [30:0] dx, dy;
  logic [27:0]        full1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    dx    <= $signed(31'd256 + {2'b00, p_col, 1'b0} - {3'b000, full0});
    dy    <= $signed(31'd256 + {2'b00, p_row, 1'b0} - {3'b000, full0});
    full1 <= full0;
  end

  // Stage 2: squares for the cone, trig products for the plane
  logic [30:0] adx_w, ady_w;
  logic [28:0] ax, ay;
  assign adx_w = dx[30] ? 31'(-dx) : 31'(dx);
  assign ady_w = dy[30] ? 31'(-dy) : 31'(dy);
  assign ax    = adx_w[28:0];   // |offset| < 2^29
  assign ay    = ady_w[28:0];

  logic               v2;
  logic [57:0]        ax2, ay2;
  logic [55:0]        r2;
  logic signed [46:0] px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ax2 <= ax * ax;
    ay2 <= ay * ay;
    r2  <= full1 * full1;
    px  <= dx * plane_sine;
    py  <= dy * plane_cosine;
  end

  // Stage 3: sum of squares, radius test, plane sum with floor and saturation
  logic [58:0]        s_sum;
  logic signed [47:0] psum;
  logic signed [32:0] zq;
  logic signed [31:0] zsat;

  assign s_sum = {1'b0, ax2} + {1'b0, ay2};
  assign psum  = 48'(px) + 48'(py);
  assign zq    = 33'(psum >>> 15);   // arithmetic shift = floor

  always_comb begin
    if (zq[32] == zq[31]) begin
      zsat = zq[31:0];
    end else if (zq[32]) begin
      zsat = 32'sh8000_0000;
    end else begin
      zsat = 32'sh7FFF_FFFF;
    end
  end

  side_t side_c [0:SQ_CELLS];
  sq_t   sq_c   [0:SQ_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_c[0].valid <= 1'b0;
    end else begin
      side_c[0].valid <= v2;
    end
    side_c[0].plane   <= (figure_kind == KIND_PLANE);
    side_c[0].neg     <= (figure_kind == KIND_DOWN);
    side_c[0].no_data <= (figure_kind != KIND_PLANE) && (s_sum >= {3'b000, r2});
    side_c[0].pval    <= zsat;
    sq_c[0].rem       <= {1'b0, s_sum};
    sq_c[0].root      <= '0;
  end

  // Square-root chain: each cell settles one bit, MSB first
  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    cpr_sqrt_cell #(
      .STAGE(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .side_in (side_c[i]),
      .sq_in   (sq_c[i]),
      .side_out(side_c[i+1]),
      .sq_out  (sq_c[i+1])
    );
  end

  // Output stage: Q.9 distance floored to Q.8, sign for cone down, plane value passed, zero on no data
  side_t              side_l;
  logic [28:0]        dist_q8;
  logic signed [31:0] height_next;

  assign side_l  = side_c[SQ_CELLS];
  assign dist_q8 = sq_c[SQ_CELLS].root[29:1];

  always_comb begin
    if (side_l.plane) begin
      height_next = side_l.pval;
    end else if (side_l.no_data) begin
      height_next = '0;
    end else if (side_l.neg) begin
      height_next = -$signed({3'b000, dist_q8});
    end else begin
      height_next = $signed({3'b000, dist_q8});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= side_l.valid;
    end
    height  <= height_next;
    no_data <= side_l.no_data;
  end

endmodule

### sv/cpr_sqrt_cell.sv
// One cell of the square-root chain: resolves one result bit per item.
// Depends on cpr_pkg (side_t, sq_t, SQ_W).
module cpr_sqrt_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  cpr_pkg::side_t side_in,
  input  cpr_pkg::sq_t   sq_in,
  output cpr_pkg::side_t side_out,
  output cpr_pkg::sq_t   sq_out
);
  import cpr_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * STAGE);

  logic [SQ_W-1:0] trial;
  sq_t             sq_next;

  always_comb begin
    trial = sq_in.root + BIT;
    if (sq_in.rem >= trial) begin
      sq_next.rem  = sq_in.rem - trial;
      sq_next.root = (sq_in.root >> 1) + BIT;
    end else begin
      sq_next.rem  = sq_in.rem;
      sq_next.root = sq_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out.valid <= side_in.valid;
    end
    side_out.plane   <= side_in.plane;
    side_out.neg     <= side_in.neg;
    side_out.no_data <= side_in.no_data;
    side_out.pval    <= side_in.pval;
    sq_out           <= sq_next;
  end

endmodule
